// ----- design/cell_pool_linked_fifo_top_macros.svh -----
// ----------------------------------------------------------------------------
// Cell pool linked FIFO assertion macros
// Shorthand for the clocked, reset-qualified properties used at the top level.
// ----------------------------------------------------------------------------
`ifndef CELL_POOL_LINKED_FIFO_TOP_MACROS_SVH
`define CELL_POOL_LINKED_FIFO_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CPLF_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CPLF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/cplf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cell pool linked FIFO package
// Field widths, operation and status codes, and controller interface types.
// ----------------------------------------------------------------------------
package cplf_pkg;

  localparam int MAX_CELLS_DEF = 64;

  localparam int KIND_W   = 3;
  localparam int CELL_W   = 6;
  localparam int STATUS_W = 2;
  localparam int REG_W    = 7;
  localparam int REG_MAX  = 64;
  localparam int GRP_N    = 8;
  localparam int GRP_W    = 3;

  localparam logic [KIND_W-1:0] KIND_ALLOC = 3'd0;
  localparam logic [KIND_W-1:0] KIND_FREE  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_ENQ   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_DEQ   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_PEEK  = 3'd4;
  localparam logic [KIND_W-1:0] KIND_NEXT  = 3'd5;

  localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NONE = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_BAD  = 2'd2;

  localparam logic REG_CPB   = 1'b0;
  localparam logic REG_LIMIT = 1'b1;

  localparam logic [REG_W-1:0] REG_RESET = 7'd8;

  typedef struct packed {
    logic clr;
    logic accept;
    logic exec;
    logic enq2;
  } cplf_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic enq_ok;
  } cplf_sts_t;

  function automatic logic [REG_W-1:0] clamp_reg(input logic [REG_W-1:0] v);
    logic [REG_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = REG_W'(1);
    end else if (v > REG_W'(REG_MAX)) begin
      r = REG_W'(REG_MAX);
    end
    return r;
  endfunction

endpackage

// ----- design/cplf_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cell pool linked FIFO controller
// Sequences the link table clearing pass and each transaction's steps.
// ----------------------------------------------------------------------------
module cplf_ctrl
  import cplf_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  cplf_sts_t sts_i,
  output cplf_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_ENQ2
  } state_e;

  state_e state_q, state_d;
  logic   busy_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (sts_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd_o.accept = 1'b1;
          state_d      = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = sts_i.enq_ok ? S_ENQ2 : S_IDLE;
      end
      S_ENQ2: begin
        cmd_o.enq2 = 1'b1;
        state_d    = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      busy_q  <= 1'b1;
    end else begin
      state_q <= state_d;
      busy_q  <= (state_d != S_IDLE);
    end
  end

  assign busy = busy_q;

endmodule

// ----- design/cplf_dpath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cell pool linked FIFO datapath
// In-use bitmap with a registered free-cell search, link table, queue ends.
// ----------------------------------------------------------------------------
module cplf_dpath
  import cplf_pkg::*;
#(
  parameter int MAX_CELLS = MAX_CELLS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cplf_cmd_t           cmd_i,
  output cplf_sts_t           sts_o,
  input  logic [KIND_W-1:0]   kind_i,
  input  logic [CELL_W-1:0]   cell_req_i,
  input  logic [REG_W-1:0]    cpb_i,
  input  logic [REG_W-1:0]    lim_i,
  output logic                result_valid_o,
  output logic [CELL_W-1:0]   result_cell_o,
  output logic [STATUS_W-1:0] status_o
);

  localparam int CW   = $clog2(MAX_CELLS);
  localparam int LW   = $clog2(MAX_CELLS + 1);
  localparam int SW   = ((LW > REG_W) ? LW : REG_W) + 1;
  localparam int CMPW = (LW > CELL_W) ? LW : CELL_W;
  localparam int NG   = (MAX_CELLS + GRP_N - 1) / GRP_N;
  localparam int GW   = (NG > 1) ? $clog2(NG) : 1;
  localparam logic [LW-1:0] NIL = LW'(MAX_CELLS);

  logic [LW-1:0]       link_mem [MAX_CELLS];
  logic [LW-1:0]       rd_q;
  logic [CW-1:0]       rd_addr;
  logic                we;
  logic [CW-1:0]       wa;
  logic [LW-1:0]       wd;

  logic [CW-1:0]       clr_addr_q;
  logic [KIND_W-1:0]   kind_q;
  logic [CELL_W-1:0]   cell_q;
  logic [MAX_CELLS-1:0] in_use_q, in_use_d;
  logic [LW-1:0]       head_q, head_d, tail_q, tail_d;
  logic [LW-1:0]       opened_q, opened_d;
  logic [REG_W-1:0]    blocks_q, blocks_d;
  logic                valid_q;
  logic [CELL_W-1:0]   res_q, res_d;
  logic [STATUS_W-1:0] status_q, status_d;

  logic                grp_free_q [NG];
  logic                grp_free_d [NG];
  logic [GRP_W-1:0]    grp_low_q  [NG];
  logic [GRP_W-1:0]    grp_low_d  [NG];

  logic [REG_W-1:0]    cpb_eff, lim_eff;
  logic [CW-1:0]       cell_idx;
  logic                cell_ok;
  logic                found;
  logic [GW-1:0]       sel_g;
  logic [CW-1:0]       alloc_idx;
  logic [SW-1:0]       grow_sum;
  logic                grow_ok;

  assign cpb_eff   = clamp_reg(cpb_i);
  assign lim_eff   = clamp_reg(lim_i);
  assign cell_idx  = CW'(cell_q);
  assign cell_ok   = CMPW'(cell_q) < CMPW'(opened_q);
  assign grow_sum  = SW'(opened_q) + SW'(cpb_eff);
  assign grow_ok   = (blocks_q < lim_eff) && (grow_sum <= SW'(MAX_CELLS));
  assign rd_addr   = (kind_i == KIND_DEQ) ? head_q[CW-1:0] : CW'(cell_req_i);

  assign sts_o.clr_last = (clr_addr_q == CW'(MAX_CELLS - 1));
  assign sts_o.enq_ok   = (kind_q == KIND_ENQ) && cell_ok;

  // Per group of eight cells: any free opened cell, and the lowest one.
  always_comb begin
    for (int g = 0; g < NG; g++) begin
      grp_free_d[g] = 1'b0;
      grp_low_d[g]  = '0;
      for (int j = GRP_N - 1; j >= 0; j--) begin
        if (g * GRP_N + j < MAX_CELLS) begin
          if (LW'(g * GRP_N + j) < opened_q && !in_use_q[CW'(g * GRP_N + j)]) begin
            grp_free_d[g] = 1'b1;
            grp_low_d[g]  = GRP_W'(j);
          end
        end
      end
    end
  end

  always_comb begin
    found = 1'b0;
    sel_g = '0;
    for (int g = NG - 1; g >= 0; g--) begin
      if (grp_free_q[g]) begin
        found = 1'b1;
        sel_g = GW'(g);
      end
    end
    alloc_idx = CW'({sel_g, grp_low_q[sel_g]});
  end

  always_comb begin
    in_use_d = in_use_q;
    head_d   = head_q;
    tail_d   = tail_q;
    opened_d = opened_q;
    blocks_d = blocks_q;
    res_d    = '0;
    status_d = STATUS_NONE;
    we       = 1'b0;
    wa       = clr_addr_q;
    wd       = NIL;
    if (cmd_i.clr) begin
      we = 1'b1;
    end
    if (cmd_i.enq2) begin
      we = 1'b1;
      wa = cell_idx;
    end
    if (cmd_i.exec) begin
      case (kind_q)
        KIND_ALLOC: begin
          if (found) begin
            in_use_d[alloc_idx] = 1'b1;
            res_d    = CELL_W'(alloc_idx);
            status_d = STATUS_OK;
          end else if (grow_ok) begin
            in_use_d[opened_q[CW-1:0]] = 1'b1;
            res_d    = CELL_W'(opened_q);
            status_d = STATUS_OK;
            opened_d = LW'(grow_sum);
            blocks_d = blocks_q + REG_W'(1);
          end
        end
        KIND_FREE: begin
          if (!cell_ok) begin
            status_d = STATUS_BAD;
          end else begin
            in_use_d[cell_idx] = 1'b0;
            we       = 1'b1;
            wa       = cell_idx;
            status_d = STATUS_OK;
          end
        end
        KIND_ENQ: begin
          if (!cell_ok) begin
            status_d = STATUS_BAD;
          end else begin
            if (tail_q != NIL) begin
              we = 1'b1;
              wa = tail_q[CW-1:0];
              wd = LW'(cell_idx);
            end
            tail_d = LW'(cell_idx);
            if (head_q == NIL) begin
              head_d = LW'(cell_idx);
            end
            status_d = STATUS_OK;
          end
        end
        KIND_DEQ: begin
          if (head_q != NIL) begin
            res_d    = CELL_W'(head_q);
            status_d = STATUS_OK;
            head_d   = rd_q;
            if (rd_q == NIL) begin
              tail_d = NIL;
            end
          end
        end
        KIND_PEEK: begin
          if (head_q != NIL) begin
            res_d    = CELL_W'(head_q);
            status_d = STATUS_OK;
          end
        end
        KIND_NEXT: begin
          if (!cell_ok) begin
            status_d = STATUS_BAD;
          end else if (rd_q != NIL) begin
            res_d    = CELL_W'(rd_q);
            status_d = STATUS_OK;
          end
        end
        default: begin
          status_d = STATUS_NONE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      link_mem[wa] <= wd;
    end
    if (cmd_i.accept) begin
      rd_q <= link_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    grp_free_q <= grp_free_d;
    grp_low_q  <= grp_low_d;
    if (cmd_i.accept) begin
      kind_q <= kind_i;
      cell_q <= cell_req_i;
    end
    if (cmd_i.exec) begin
      res_q    <= res_d;
      status_q <= status_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
      in_use_q   <= '0;
      head_q     <= NIL;
      tail_q     <= NIL;
      opened_q   <= '0;
      blocks_q   <= '0;
      valid_q    <= 1'b0;
    end else begin
      if (cmd_i.clr) begin
        clr_addr_q <= clr_addr_q + CW'(1);
      end
      in_use_q <= in_use_d;
      head_q   <= head_d;
      tail_q   <= tail_d;
      opened_q <= opened_d;
      blocks_q <= blocks_d;
      valid_q  <= cmd_i.exec;
    end
  end

  assign result_valid_o = valid_q;
  assign result_cell_o  = res_q;
  assign status_o       = status_q;

endmodule

// ----- design/cell_pool_linked_fifo_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cell pool linked FIFO
// Block-grown cell pool with an in-use bitmap and one linked FIFO of cells.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over the link table, one entry
// per cycle over all MAX_CELLS entries, with busy high. A transaction is
// taken when start is high and busy is low. For alloc, free, dequeue, peek
// and next the link table is read at the accept edge and the operation
// executes in the following cycle. A valid enqueue adds a step to write two
// link table entries through the single write port. Each result appears on
// result_cell_o and status_o for exactly one cycle with result_valid_o high,
// in the cycle after the execute step; the receiver cannot stall it. The next
// transaction may be accepted at the edge that ends that result cycle, or
// after a valid enqueue's extra step. Configuration writes take effect at
// once and should be issued only while the block is idle.
module cell_pool_linked_fifo_top
  import cplf_pkg::*;
#(
  parameter int MAX_CELLS = MAX_CELLS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic [KIND_W-1:0]   kind_i,
  input  logic [CELL_W-1:0]   cell_req_i,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [REG_W-1:0]    cfg_wdata_i,
  output logic                result_valid_o,
  output logic [CELL_W-1:0]   result_cell_o,
  output logic [STATUS_W-1:0] status_o
);

`include "cell_pool_linked_fifo_top_macros.svh"

  cplf_cmd_t        cmd;
  cplf_sts_t        sts;
  logic [REG_W-1:0] cpb_q;
  logic [REG_W-1:0] lim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cpb_q <= REG_RESET;
      lim_q <= REG_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_CPB:   cpb_q <= cfg_wdata_i;
        REG_LIMIT: lim_q <= cfg_wdata_i;
        default:   cpb_q <= cpb_q;
      endcase
    end
  end

  cplf_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  cplf_dpath #(
    .MAX_CELLS (MAX_CELLS)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .kind_i         (kind_i),
    .cell_req_i     (cell_req_i),
    .cpb_i          (cpb_q),
    .lim_i          (lim_q),
    .result_valid_o (result_valid_o),
    .result_cell_o  (result_cell_o),
    .status_o       (status_o)
  );

  `CPLF_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "busy not raised after a transaction")
  `CPLF_ASSERT_SAME(a_result_after_busy, result_valid_o, $past(busy), "result without a transaction")
  `CPLF_ASSERT_NEXT(a_result_single, result_valid_o, !result_valid_o, "result strobe held too long")
  `CPLF_ASSERT_SAME(a_fail_zero, result_valid_o && status_o != STATUS_OK, result_cell_o == '0, "failed result carries a cell")

endmodule

// ----- verif/cell_pool_linked_fifo_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cell pool linked FIFO checker
// Watches the command, configuration and result ports of the cell pool, keeps
// its own copy of the pool and FIFO state, predicts the reply to every accepted
// transaction and compares each reply field by field in order of issue.
// ----------------------------------------------------------------------------
module cell_pool_linked_fifo_checker
  import cplf_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                txn_start_i,
  input  logic                txn_busy_i,
  input  logic [KIND_W-1:0]   kind_i,
  input  logic [CELL_W-1:0]   cell_req_i,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [REG_W-1:0]    cfg_wdata_i,
  input  logic                rsp_valid_i,
  input  logic [CELL_W-1:0]   rsp_cell_i,
  input  logic [STATUS_W-1:0] rsp_status_i,
  output int                  fail_count_o,
  output int                  pending_o
);

  localparam int POOL_CELLS = 64;
  localparam logic [6:0] LINK_NULL = 7'd64;

  typedef struct packed {
    logic [CELL_W-1:0]   cell_idx;
    logic [STATUS_W-1:0] status;
  } pool_reply_t;

  logic [REG_W-1:0] cells_per_block;
  logic [REG_W-1:0] block_limit;
  logic             cell_used [POOL_CELLS];
  logic [6:0]       link_of [POOL_CELLS];
  logic [6:0]       fifo_head;
  logic [6:0]       fifo_tail;
  int               blocks_open;
  int               cells_open;

  pool_reply_t expected_replies[$];
  int          errors = 0;

  function automatic int effective_reg(input logic [REG_W-1:0] v);
    int n;
    n = int'(v);
    if (n < 1) n = 1;
    if (n > 64) n = 64;
    return n;
  endfunction

  task automatic clear_pool_state();
    int i;
    cells_per_block = REG_RESET;
    block_limit     = REG_RESET;
    for (i = 0; i < POOL_CELLS; i++) begin
      cell_used[i] = 1'b0;
      link_of[i]   = LINK_NULL;
    end
    fifo_head   = LINK_NULL;
    fifo_tail   = LINK_NULL;
    blocks_open = 0;
    cells_open  = 0;
  endtask

  task automatic report(input string what);
    if (errors < 100) begin
      $display("%0t ns: mismatch: %s", $time, what);
    end
    errors++;
  endtask

  task automatic predict_pool_op(input logic [KIND_W-1:0] op, input logic [CELL_W-1:0] idx,
                                 output pool_reply_t r);
    int  i;
    int  step;
    int  lim;
    bit  found;
    bit  opened;
    logic [6:0] nx;
    r.cell_idx = '0;
    r.status   = STATUS_NONE;
    opened     = int'(idx) < cells_open;
    case (op)
      KIND_ALLOC: begin
        step  = effective_reg(cells_per_block);
        lim   = effective_reg(block_limit);
        found = 1'b0;
        for (i = 0; i < POOL_CELLS; i++) begin
          if (!found && i < cells_open && !cell_used[i]) begin
            found        = 1'b1;
            cell_used[i] = 1'b1;
            r.cell_idx   = CELL_W'(i);
            r.status     = STATUS_OK;
          end
        end
        if (!found && blocks_open < lim && cells_open + step <= POOL_CELLS) begin
          r.cell_idx            = CELL_W'(cells_open);
          r.status              = STATUS_OK;
          cell_used[cells_open] = 1'b1;
          cells_open            = cells_open + step;
          blocks_open++;
        end
      end
      KIND_FREE: begin
        if (!opened) begin
          r.status = STATUS_BAD;
        end else begin
          cell_used[idx] = 1'b0;
          link_of[idx]   = LINK_NULL;
          r.status       = STATUS_OK;
        end
      end
      KIND_ENQ: begin
        if (!opened) begin
          r.status = STATUS_BAD;
        end else begin
          if (fifo_tail != LINK_NULL) link_of[fifo_tail[5:0]] = {1'b0, idx};
          link_of[idx] = LINK_NULL;
          fifo_tail    = {1'b0, idx};
          if (fifo_head == LINK_NULL) fifo_head = {1'b0, idx};
          r.status = STATUS_OK;
        end
      end
      KIND_DEQ: begin
        if (fifo_head != LINK_NULL) begin
          nx         = link_of[fifo_head[5:0]];
          r.cell_idx = fifo_head[5:0];
          r.status   = STATUS_OK;
          fifo_head  = nx;
          if (nx == LINK_NULL) fifo_tail = LINK_NULL;
        end
      end
      KIND_PEEK: begin
        if (fifo_head != LINK_NULL) begin
          r.cell_idx = fifo_head[5:0];
          r.status   = STATUS_OK;
        end
      end
      KIND_NEXT: begin
        if (!opened) begin
          r.status = STATUS_BAD;
        end else if (link_of[idx] != LINK_NULL) begin
          r.cell_idx = link_of[idx][5:0];
          r.status   = STATUS_OK;
        end
      end
      default: begin
      end
    endcase
    if (r.status != STATUS_OK) r.cell_idx = '0;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    pool_reply_t want;
    pool_reply_t got;
    if (!rst_ni) begin
      clear_pool_state();
      expected_replies.delete();
      pending_o    <= 0;
      fail_count_o <= errors;
    end else begin
      if (rsp_valid_i) begin
        if (expected_replies.size() == 0) begin
          report($sformatf("reply cell %0d status %0d with no transaction outstanding",
                           rsp_cell_i, rsp_status_i));
        end else begin
          want = expected_replies.pop_front();
          if (rsp_status_i !== want.status) begin
            report($sformatf("status %0d, expected %0d", rsp_status_i, want.status));
          end
          if (rsp_cell_i !== want.cell_idx) begin
            report($sformatf("result cell %0d, expected %0d", rsp_cell_i, want.cell_idx));
          end
        end
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_CPB) cells_per_block = cfg_wdata_i;
        else if (cfg_idx_i == REG_LIMIT) block_limit = cfg_wdata_i;
      end
      if (txn_start_i && !txn_busy_i) begin
        predict_pool_op(kind_i, cell_req_i, got);
        expected_replies.push_back(got);
      end
      pending_o    <= expected_replies.size();
      fail_count_o <= errors;
    end
  end

endmodule

// ----- verif/cell_pool_linked_fifo_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cell pool linked FIFO testbench
// Drives directed and random pool and FIFO transactions through several block
// size and block limit settings, with random sender gaps in most phases, and
// lets the checker compare every reply against its own model of the pool.
// ----------------------------------------------------------------------------
module cell_pool_linked_fifo_top_tb;
  import cplf_pkg::*;

  localparam logic [KIND_W-1:0] KIND_UNDEF_A = 3'd6;
  localparam logic [KIND_W-1:0] KIND_UNDEF_B = 3'd7;
  localparam int STALL_LIMIT = 3000;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic [KIND_W-1:0]   kind_i = '0;
  logic [CELL_W-1:0]   cell_req_i = '0;
  logic                cfg_we_i = 1'b0;
  logic                cfg_idx_i = 1'b0;
  logic [REG_W-1:0]    cfg_wdata_i = '0;
  logic                result_valid_o;
  logic [CELL_W-1:0]   result_cell_o;
  logic [STATUS_W-1:0] status_o;
  int                  fail_count;
  int                  pending;
  int                  stall_cycles = 0;

  always #10 clk_i = ~clk_i;

  cell_pool_linked_fifo_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .kind_i         (kind_i),
    .cell_req_i     (cell_req_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .result_valid_o (result_valid_o),
    .result_cell_o  (result_cell_o),
    .status_o       (status_o)
  );

  cell_pool_linked_fifo_checker pool_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .txn_start_i  (start),
    .txn_busy_i   (busy),
    .kind_i       (kind_i),
    .cell_req_i   (cell_req_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .rsp_valid_i  (result_valid_o),
    .rsp_cell_i   (result_cell_o),
    .rsp_status_i (status_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always @(posedge clk_i) begin
    if ((start && !busy) || result_valid_o || cfg_we_i) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic send_op(input logic [KIND_W-1:0] op, input int idx, input bit idle_ok);
    if (idle_ok && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    start      <= 1'b1;
    kind_i     <= op;
    cell_req_i <= CELL_W'(idx);
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic drain_replies();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic set_pool_regs(input int cpb, input int lim);
    drain_replies();
    repeat (4) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= REG_CPB;
    cfg_wdata_i <= REG_W'(cpb);
    @(posedge clk_i);
    cfg_idx_i   <= REG_LIMIT;
    cfg_wdata_i <= REG_W'(lim);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  function automatic int pick_cell(input int span);
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 63);
    return $urandom_range(0, span);
  endfunction

  task automatic run_phase(input int span, input int items, input bit idle_ok);
    int n;
    int r;
    int k;
    int burst;
    bit paused;
    n      = 0;
    paused = 1'b0;
    while (n < items) begin
      if ($urandom_range(0, 3) == 0) begin
        burst = $urandom_range(2, 6);
        for (k = 0; k < burst; k++) send_op(KIND_ENQ, pick_cell(span), idle_ok);
        for (k = 0; k < burst; k++) begin
          if ($urandom_range(0, 4) == 0) send_op(KIND_NEXT, pick_cell(span), idle_ok);
          else send_op(KIND_DEQ, pick_cell(span), idle_ok);
        end
        n += 2 * burst;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 22) send_op(KIND_ALLOC, $urandom_range(0, 63), idle_ok);
        else if (r < 36) send_op(KIND_FREE, pick_cell(span), idle_ok);
        else if (r < 56) send_op(KIND_ENQ, pick_cell(span), idle_ok);
        else if (r < 74) send_op(KIND_DEQ, $urandom_range(0, 63), idle_ok);
        else if (r < 82) send_op(KIND_PEEK, $urandom_range(0, 63), idle_ok);
        else if (r < 94) send_op(KIND_NEXT, pick_cell(span), idle_ok);
        else if (r < 97) send_op(KIND_UNDEF_A, $urandom_range(0, 63), idle_ok);
        else send_op(KIND_UNDEF_B, $urandom_range(0, 63), idle_ok);
        n++;
      end
      if (!paused && idle_ok && n >= items / 2) begin
        paused = 1'b1;
        drain_replies();
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_op(KIND_PEEK, 0, 1'b1);
    send_op(KIND_DEQ, 63, 1'b1);
    send_op(KIND_NEXT, 0, 1'b1);
    send_op(KIND_FREE, 63, 1'b1);
    send_op(KIND_ENQ, 0, 1'b1);
    send_op(KIND_UNDEF_A, 0, 1'b1);
    send_op(KIND_UNDEF_B, 63, 1'b1);
    send_op(KIND_ALLOC, 63, 1'b1);
    send_op(KIND_ALLOC, 0, 1'b1);
    send_op(KIND_ALLOC, 0, 1'b1);
    send_op(KIND_NEXT, 7, 1'b1);
    send_op(KIND_NEXT, 8, 1'b1);
    send_op(KIND_ENQ, 0, 1'b1);
    send_op(KIND_ENQ, 1, 1'b1);
    send_op(KIND_ENQ, 1, 1'b1);
    send_op(KIND_ENQ, 2, 1'b1);
    send_op(KIND_PEEK, 0, 1'b1);
    send_op(KIND_NEXT, 0, 1'b1);
    send_op(KIND_DEQ, 0, 1'b1);
    send_op(KIND_FREE, 1, 1'b1);
    send_op(KIND_DEQ, 0, 1'b1);
    send_op(KIND_DEQ, 0, 1'b1);
    send_op(KIND_FREE, 0, 1'b1);
    send_op(KIND_ALLOC, 0, 1'b1);
    send_op(KIND_ENQ, 8, 1'b1);

    set_pool_regs(1, 1);
    run_phase(15, 90, 1'b1);
    set_pool_regs(0, 0);
    run_phase(15, 80, 1'b1);
    set_pool_regs(127, 127);
    run_phase(15, 80, 1'b1);
    set_pool_regs(3, 20);
    run_phase(40, 100, 1'b1);
    set_pool_regs(64, 64);
    run_phase(63, 80, 1'b1);
    set_pool_regs(1, 64);
    run_phase(63, 120, 1'b1);
    set_pool_regs($urandom_range(0, 127), $urandom_range(0, 127));
    run_phase(63, 80, 1'b1);
    set_pool_regs($urandom_range(0, 127), $urandom_range(0, 127));
    run_phase(63, 80, 1'b1);
    set_pool_regs(8, 8);
    run_phase(63, 100, 1'b0);

    drain_replies();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
